@@ design/ordered_list_store_assert.svh @@
// Assertion macros shared by the ordered list store checker.
`ifndef ORDERED_LIST_STORE_ASSERT_SVH
`define ORDERED_LIST_STORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define OLS_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define OLS_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/olst_pkg.sv @@
// Shared types, widths and codes of the ordered list store.
package olst_pkg;

    localparam int unsigned DATA_W       = 32;
    localparam int unsigned CNT_W        = 5;
    localparam int unsigned TYPE_W       = 3;
    localparam int unsigned IDX_W        = 11;
    localparam int unsigned ADDR_W       = 3;
    localparam int unsigned PDATA_W      = 32;
    localparam int unsigned DEF_CAPACITY = 16;

    localparam logic [CNT_W-1:0] CAP_RESET        = 5'd16;
    localparam logic [0:0]       REG_CAPACITY_IDX = 1'b0;

    typedef enum logic [TYPE_W-1:0] {
        REQ_APPEND  = 3'd0,
        REQ_INSERT  = 3'd1,
        REQ_DELETE  = 3'd2,
        REQ_GET     = 3'd3,
        REQ_SORT    = 3'd4,
        REQ_REVERSE = 3'd5
    } req_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_DELETE,
        CELL_SORT,
        CELL_REVERSE
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [CNT_W-1:0]   key;
        logic [CNT_W-1:0]   count;
        logic               phase;
        logic [DATA_W-1:0]  value;
    } cell_ctrl_t;

endpackage

@@ design/ordered_list_store.sv @@
// Top level of the ordered list store: request decode, cell row and result register.
// Append, insert, delete, get and rejected requests: result is registered on
// acceptance, and a new request can be taken every cycle while results drain.
// Sort and reverse of two or more entries run one transposition round per entry, then load
// the result and block new requests meanwhile; a shorter list loads it on acceptance.
// Reset (rst_n, asynchronous, active low) empties the list and sets the capacity register
// to 16; stored words are undefined until written.
module ordered_list_store #(
    parameter int unsigned CAPACITY = olst_pkg::DEF_CAPACITY
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [olst_pkg::ADDR_W-1:0]         paddr,
    input  logic [olst_pkg::PDATA_W-1:0]        pwdata,
    output logic [olst_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    // Request channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [olst_pkg::TYPE_W-1:0]         req_type,
    input  logic [olst_pkg::CNT_W-1:0]          position,
    input  logic signed [olst_pkg::DATA_W-1:0]  value,
    // Result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                ok,
    output logic signed [olst_pkg::DATA_W-1:0]  read_value,
    output logic [olst_pkg::CNT_W-1:0]          entry_total,
    output logic                                is_empty,
    output logic                                is_full
);
    import olst_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    // Control and result registers.
    state_t            state_reg,     state_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [CNT_W-1:0]  round_reg,     round_next;
    cell_op_t          run_op_reg,    run_op_next;
    logic [CNT_W-1:0]  cap_reg,       cap_next;
    logic              out_valid_reg, out_valid_next;
    logic              ok_reg,        ok_next;
    logic [DATA_W-1:0] rdv_reg,       rdv_next;
    logic [CNT_W-1:0]  total_reg,     total_next;
    logic              empty_reg,     empty_next;
    logic              full_reg,      full_next;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    cell_ctrl_t        ctrl;

    logic              accept;
    logic              cfg_write;
    logic [0:0]        cfg_idx;
    logic [IDX_W-1:0]  lim;
    logic [IDX_W-1:0]  cap_w;
    logic              room;
    logic              pos_rd_ok;
    logic              pos_ins_ok;
    logic [CNT_W-1:0]  key_pos;
    logic [DATA_W-1:0] rd_word;
    logic              load;
    logic              load_ok;
    logic [DATA_W-1:0] load_rd;
    logic [CNT_W-1:0]  load_count;

    // The limit in force is the smaller of the register and the number of cells.
    assign cap_w      = IDX_W'(cap_reg);
    assign lim        = (cap_w < IDX_W'(CAPACITY)) ? cap_w : IDX_W'(CAPACITY);
    assign room       = IDX_W'(count_reg) < lim;
    assign pos_rd_ok  = (position != '0) && (position <= count_reg);
    assign pos_ins_ok = (position != '0)
                        && ({1'b0, position} <= ({1'b0, count_reg} + (CNT_W + 1)'(1)));
    assign key_pos    = position - CNT_W'(1);

    // Only one cell matches the position, so the read is an AND-OR over the row.
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (IDX_W'(i) == IDX_W'(key_pos))
            begin
                rd_word = rd_word | cell_data[i];
            end
        end
    end

    // Configuration port: a single capacity register at offset zero.
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (cfg_idx == REG_CAPACITY_IDX) ? PDATA_W'(cap_reg) : '0;

    // A request is taken when idle and the result register is free or draining.
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        round_next     = round_reg;
        run_op_next    = run_op_reg;
        cap_next       = cap_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ok_next        = ok_reg;
        rdv_next       = rdv_reg;
        total_next     = total_reg;
        empty_next     = empty_reg;
        full_next      = full_reg;
        load           = 1'b0;
        load_ok        = 1'b0;
        load_rd        = '0;
        load_count     = count_reg;
        ctrl.op        = CELL_HOLD;
        ctrl.key       = count_reg;
        ctrl.count     = count_reg;
        ctrl.phase     = round_reg[0];
        ctrl.value     = value;

        if (cfg_write && (cfg_idx == REG_CAPACITY_IDX))
        begin
            cap_next = pwdata[CNT_W-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load = 1'b1;
                    unique case (req_t'(req_type))
                        REQ_APPEND:
                        begin
                            if (room)
                            begin
                                ctrl.op    = CELL_APPEND;
                                ctrl.key   = count_reg;
                                load_ok    = 1'b1;
                                load_count = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (room && pos_ins_ok)
                            begin
                                ctrl.op    = CELL_INSERT;
                                ctrl.key   = key_pos;
                                load_ok    = 1'b1;
                                load_count = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (pos_rd_ok)
                            begin
                                ctrl.op    = CELL_DELETE;
                                ctrl.key   = key_pos;
                                load_ok    = 1'b1;
                                load_rd    = rd_word;
                                load_count = count_reg - CNT_W'(1);
                            end
                        end
                        REQ_GET:
                        begin
                            if (pos_rd_ok)
                            begin
                                load_ok = 1'b1;
                                load_rd = rd_word;
                            end
                        end
                        REQ_SORT:
                        begin
                            load_ok = 1'b1;
                            if (count_reg > CNT_W'(1))
                            begin
                                load        = 1'b0;
                                state_next  = S_RUN;
                                round_next  = '0;
                                run_op_next = CELL_SORT;
                            end
                        end
                        REQ_REVERSE:
                        begin
                            load_ok = 1'b1;
                            if (count_reg > CNT_W'(1))
                            begin
                                load        = 1'b0;
                                state_next  = S_RUN;
                                round_next  = '0;
                                run_op_next = CELL_REVERSE;
                            end
                        end
                        default:
                        begin
                            load_ok = 1'b0;
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                // One transposition round per cycle; count rounds finish any order.
                if (round_reg < count_reg)
                begin
                    ctrl.op    = run_op_reg;
                    round_next = round_reg + CNT_W'(1);
                end
                else if (!out_valid_reg || out_ready)
                begin
                    load       = 1'b1;
                    load_ok    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
            ok_next        = load_ok;
            rdv_next       = load_rd;
            total_next     = load_count;
            count_next     = load_count;
            empty_next     = (load_count == '0);
            full_next      = IDX_W'(load_count) >= lim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            round_reg     <= '0;
            run_op_reg    <= CELL_HOLD;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            rdv_reg       <= '0;
            total_reg     <= '0;
            empty_reg     <= 1'b1;
            full_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            round_reg     <= round_next;
            run_op_reg    <= run_op_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
            ok_reg        <= ok_next;
            rdv_reg       <= rdv_next;
            total_reg     <= total_next;
            empty_reg     <= empty_next;
            full_reg      <= full_next;
        end
    end

    // The row of cells; each end sees zero beyond the row, which is never selected.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[g+1];
        end

        olst_cell #(
            .IDX(g)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[g])
        );
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign read_value  = $signed(rdv_reg);
    assign entry_total = total_reg;
    assign is_empty    = empty_reg;
    assign is_full     = full_reg;

endmodule

@@ design/olst_cell.sv @@
// One storage cell of the list row, exchanging words with its two neighbors.
module olst_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                        clk,
    input  olst_pkg::cell_ctrl_t        ctrl,
    input  logic [olst_pkg::DATA_W-1:0] left_data,
    input  logic [olst_pkg::DATA_W-1:0] right_data,
    output logic [olst_pkg::DATA_W-1:0] data
);
    import olst_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [IDX_W-1:0]  key_w;
    logic [IDX_W-1:0]  cnt_w;
    logic              pair_left;
    logic              right_in;
    logic              here_in;
    logic              gt_right;
    logic              gt_left;
    logic              swap_all;

    always_comb
    begin
        key_w     = IDX_W'(ctrl.key);
        cnt_w     = IDX_W'(ctrl.count);
        pair_left = (MY_IDX[0] == ctrl.phase);
        right_in  = (MY_IDX + IDX_W'(1)) < cnt_w;
        here_in   = MY_IDX < cnt_w;
        gt_right  = $signed(data_reg) > $signed(right_data);
        gt_left   = $signed(left_data) > $signed(data_reg);
        swap_all  = (ctrl.op == CELL_REVERSE);
        data_next = data_reg;
        case (ctrl.op) inside
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_APPEND:
            begin
                if (MY_IDX == key_w)
                begin
                    data_next = ctrl.value;
                end
            end
            CELL_INSERT:
            begin
                if (MY_IDX == key_w)
                begin
                    data_next = ctrl.value;
                end
                else if (MY_IDX > key_w)
                begin
                    data_next = left_data;
                end
            end
            CELL_DELETE:
            begin
                if (MY_IDX >= key_w)
                begin
                    data_next = right_data;
                end
            end
            CELL_SORT, CELL_REVERSE:
            begin
                // Odd-even transposition: the phase picks which neighbor is the partner.
                if (pair_left)
                begin
                    if (right_in && (swap_all || gt_right))
                    begin
                        data_next = right_data;
                    end
                end
                else if (here_in && (MY_IDX != '0) && (swap_all || gt_left))
                begin
                    data_next = left_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ design/olst_checker.sv @@
// Port-level checks of the ordered list store and their binding to the top level.
`include "ordered_list_store_assert.svh"

module olst_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic                                ok,
    input logic signed [olst_pkg::DATA_W-1:0]  read_value,
    input logic [olst_pkg::CNT_W-1:0]          entry_total,
    input logic                                is_empty
);
    import olst_pkg::*;

    // After a request is taken, either its result shows or the block is busy.
    `OLS_CHECK_NEXT(a_accept_then_busy, in_valid && in_ready, out_valid || !in_ready, "request accepted without result or busy")

    // A rejected request never returns a word.
    `OLS_CHECK_NOW(a_reject_zero, out_valid && !ok, read_value == '0, "rejected request returned data")

    // The empty flag agrees with the count it travels with.
    `OLS_CHECK_NOW(a_empty_count, out_valid, is_empty == (entry_total == '0), "empty flag disagrees with count")

    // A stalled result holds.
    `OLS_CHECK_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(read_value) && $stable(entry_total), "stalled result changed")

endmodule

bind ordered_list_store olst_checker u_olst_checker (.*);
